FILE: rtl/frq_pkg.sv
// Shared types and codes for the floor request queue.
package frq_pkg;

   // Request kinds carried in the request beat
   typedef enum logic [1:0] {
      REQ_PRESS = 2'd0,
      REQ_SERVE = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   // Button codes; the fourth code is not a button
   localparam logic [1:0] BTN_DOWN    = 2'd0;
   localparam logic [1:0] BTN_UP      = 2'd1;
   localparam logic [1:0] BTN_INSIDE  = 2'd2;
   localparam logic [1:0] BTN_INVALID = 2'd3;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_FINISH
   } frq_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture the request beat
      logic apply;   // update call bits or clear everything
      logic step;    // examine one queue slot
      logic finish;  // load the response register
   } frq_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_scan;  // request walks the queue
      logic step_last;  // current slot ends the walk
      logic out_free;   // response register can take a new beat
   } frq_status_type;

endpackage

FILE: rtl/frq_ctrl.sv
// Controller state machine sequencing one request through the datapath.
module frq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  frq_pkg::frq_status_type status,
   output frq_pkg::frq_cmd_type    cmd
);
   import frq_pkg::*;

   frq_state_type state_ff;
   frq_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.need_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A response is loaded only into a free output register
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("response loaded while output register busy");

   // Every accepted beat is followed by its apply step
   a_load_apply: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.apply)
      else $error("accepted beat not applied");

endmodule

FILE: rtl/frq_datapath.sv
// Datapath: queue slots, call button table, slot walker and response register.
module frq_datapath #(
   parameter int FLOORS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [frq_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [frq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  frq_pkg::frq_cmd_type                cmd,
   output frq_pkg::frq_status_type             status
);
   import frq_pkg::*;

   localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(FLOORS - 1);

   // Queue slots, call table and captured request
   logic [FLOORS-1:0]          q_valid_ff, q_valid_in;
   logic [FLOORS-1:0][1:0]     q_floor_ff, q_floor_in;
   logic [FLOORS-1:0][2:0]     call_ff, call_in;
   req_kind_type               kind_ff;
   logic [1:0]                 floor_ff;
   logic [1:0]                 button_ff;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       rsp_valid_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;

   logic [IDX_W-1:0]           fidx;
   logic                       f_ok;
   logic                       btn_ok;
   logic                       cur_v;
   logic                       match;
   logic [2:0]                 mask;
   logic [RSP_DATA_W-1:0]      rsp_word;

   assign fidx   = IDX_W'(floor_ff);
   assign f_ok   = int'(floor_ff) < FLOORS;
   assign btn_ok = button_ff != BTN_INVALID;
   assign cur_v  = q_valid_ff[idx_ff];
   assign match  = cur_v && (q_floor_ff[idx_ff] == floor_ff);

   // Status toward the controller
   assign status.need_scan = f_ok && ((kind_ff == REQ_PRESS && btn_ok) ||
                                      kind_ff == REQ_SERVE);
   assign status.step_last = match || !cur_v || (idx_ff == LAST_SLOT);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // Next state of the queue, call table and slot walker
   always_comb begin
      q_valid_in = q_valid_ff;
      q_floor_in = q_floor_ff;
      call_in    = call_ff;
      idx_in     = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end
      if (cmd.apply) begin
         if (kind_ff == REQ_CLEAR) begin
            q_valid_in = '0;
            q_floor_in = '0;
            call_in    = '0;
         end else if (kind_ff == REQ_PRESS && f_ok && btn_ok) begin
            call_in[fidx] = call_ff[fidx] | (3'b001 << button_ff);
         end else if (kind_ff == REQ_SERVE && f_ok) begin
            call_in[fidx] = '0;
         end
      end
      if (cmd.step) begin
         if (kind_ff == REQ_PRESS) begin
            // append in the first empty slot unless already queued
            if (!cur_v) begin
               q_valid_in[idx_ff] = 1'b1;
               q_floor_in[idx_ff] = floor_ff;
            end
         end else if (match) begin
            // drop the served slot and shift later slots forward
            for (int j = 0; j < FLOORS - 1; j++) begin
               if (j >= int'(idx_ff)) begin
                  q_valid_in[j] = q_valid_ff[j + 1];
                  q_floor_in[j] = q_floor_ff[j + 1];
               end
            end
            q_valid_in[FLOORS-1] = 1'b0;
            q_floor_in[FLOORS-1] = '0;
         end
         if (!status.step_last) begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= '0;
         q_floor_ff   <= '0;
         call_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
         q_floor_ff <= q_floor_in;
         call_ff    <= call_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: request capture, walker index, response beat
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         kind_ff   <= req_kind_type'(req_tdata[1:0]);
         floor_ff  <= req_tdata[3:2];
         button_ff <= req_tdata[5:4];
      end
      if (cmd.finish) begin
         rsp_data_ff <= rsp_word;
      end
   end

   // Assemble the response from the state after the step
   always_comb begin
      mask     = f_ok ? call_ff[fidx] : 3'b000;
      rsp_word = '0;
      rsp_word[0]   = !q_valid_ff[0];
      rsp_word[1]   = q_valid_ff[0];
      rsp_word[3:2] = q_valid_ff[0] ? q_floor_ff[0] : 2'd0;
      rsp_word[4]   = mask != 3'b000;
      rsp_word[7:5] = mask;
      rsp_word[8]   = kind_ff == REQ_CLEAR;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The queue stays packed toward slot zero
   for (genvar g = 0; g < FLOORS - 1; g++) begin : g_packed
      a_packed: assert property (@(posedge clock) disable iff (reset)
         !q_valid_ff[g] |-> !q_valid_ff[g + 1])
         else $error("queue slot %0d empty ahead of a filled slot", g);
   end

   // Clear-all leaves the queue empty
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && kind_ff == REQ_CLEAR) |=> (q_valid_ff == '0))
      else $error("queue not empty after clear-all");

   // A response with all lamps off reports an empty queue
   a_off_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |-> rsp_tdata[0])
      else $error("lamps off reported with a nonempty queue");

endmodule

FILE: rtl/floor_request_queue_unit.sv
// Top level of the floor request queue: controller plus datapath.
//
// Request channel (req_): one beat per event: button press, floor served,
// clear all or status query. Response channel (rsp_): exactly one beat per
// request, in order, giving the queue head, the request floor's call lamps
// and whether the request was a clear-all, which switches all lamps off.
// One request is worked on at a time. A clear-all or query passes from the
// accepting state through the apply and finish states; a valid press or
// serve also passes through the scan state, where the slot walker examines
// k queue slots (1 to FLOORS), one per cycle, to find a duplicate, a free
// slot or the served floor. A served slot and all later ones shift forward
// together.
// The response sits in an output register, so the next request is taken as
// soon as the previous one is loaded there. If the receiver stalls, the
// held response blocks only the final step of the following request.
// Reset empties the queue, clears every call bit and drops any pending
// response; req_tready is low during reset and rises once it is released.
module floor_request_queue_unit #(
   parameter int FLOORS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [1:0] req_type, [3:2] floor, [5:4] button, [7:6] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [frq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: [0] queue_empty, [1] head_valid, [3:2] head_floor,
   //            [4] floor_has_calls, [7:5] lamp_mask, [8] lamps_all_off,
   //            [15:9] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [frq_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import frq_pkg::*;

   frq_cmd_type    cmd;
   frq_status_type status;

   // Sequencer
   frq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Queue, call table and response register
   frq_datapath #(
      .FLOORS (FLOORS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
